/* sv/mcmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmt_pkg: shared constants and types
// Widths, register indexes, reset values and sequencer types for the masked
// colour mean threshold block.
// ----------------------------------------------------------------------------
package mcmt_pkg;

    localparam int FRAME_PIXELS_LOG2 = 20;
    localparam int CNT_W   = FRAME_PIXELS_LOG2 + 1;
    localparam int SUM_W   = FRAME_PIXELS_LOG2 + 9;
    localparam int PIX_W   = 8;
    localparam int QUO_W   = 8;
    localparam int STEP_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SAT_FLOOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_MARGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SV_MARGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_CEILING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_CEILING = 3'd4;

    localparam logic [PIX_W-1:0] RST_SAT_FLOOR  = 8'd50;
    localparam logic [PIX_W-1:0] RST_HUE_MARGIN = 8'd5;
    localparam logic [PIX_W-1:0] RST_SV_MARGIN  = 8'd50;
    localparam logic [PIX_W-1:0] PIX_MAX        = 8'd255;

    localparam logic [1:0] CH_HUE    = 2'd0;
    localparam logic [1:0] CH_SAT    = 2'd1;
    localparam logic [1:0] CH_BRIGHT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic take;
        logic clr;
    } t_acc_ctl;

endpackage

/* sv/mcmt_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmt_accum: masked pixel accumulator
// Counts pixels above the saturation floor and sums their three channels,
// holding at the frame cap.
// ----------------------------------------------------------------------------
module mcmt_accum
    import mcmt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_acc_ctl         i_ctl,
    input  logic [PIX_W-1:0] i_hue,
    input  logic [PIX_W-1:0] i_sat,
    input  logic [PIX_W-1:0] i_bright,
    input  logic [PIX_W-1:0] i_sat_floor,
    output logic [CNT_W-1:0] o_count,
    output logic [SUM_W-1:0] o_hue_sum,
    output logic [SUM_W-1:0] o_sat_sum,
    output logic [SUM_W-1:0] o_bright_sum
);

    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_hue_sum, r_sat_sum, r_bright_sum;
    logic             w_add;

    // top bit of the count set means the cap has been reached
    assign w_add = i_ctl.take && (i_sat > i_sat_floor) && !r_count[CNT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_count      <= '0;
            r_hue_sum    <= '0;
            r_sat_sum    <= '0;
            r_bright_sum <= '0;
        end else if (w_add) begin
            r_count      <= r_count + CNT_W'(1);
            r_hue_sum    <= r_hue_sum + SUM_W'(i_hue);
            r_sat_sum    <= r_sat_sum + SUM_W'(i_sat);
            r_bright_sum <= r_bright_sum + SUM_W'(i_bright);
        end
    end

    assign o_count      = r_count;
    assign o_hue_sum    = r_hue_sum;
    assign o_sat_sum    = r_sat_sum;
    assign o_bright_sum = r_bright_sum;

endmodule

/* sv/mcmt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmt_div: shared restoring divider
// One quotient bit per cycle; the quotient of a mean always fits 8 bits, so
// the divisor starts shifted up by 7 and moves down one place a step.
// ----------------------------------------------------------------------------
module mcmt_div
    import mcmt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    logic [SUM_W-1:0]  r_rem, r_den;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy, r_done;
    logic [SUM_W:0]    w_diff;

    assign w_diff = {1'b0, r_rem} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= SUM_W'(i_divisor) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            r_den <= r_den >> 1;
            if (!w_diff[SUM_W]) begin
                r_rem <= w_diff[SUM_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* sv/masked_color_mean_threshold.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_color_mean_threshold: colour threshold from masked frame means
// Accumulates pixels above a saturation floor and, at frame end, turns the
// three channel means into a low/high threshold word.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  pixel     in         i_valid / o_stall       i_hue i_sat i_bright i_frame_end
//  result    out        o_valid / i_stall       o_low_* o_high_* o_empty_res
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
//  Ordinary pixels are taken one per cycle while o_stall is low. A frame-end
//  pixel raises o_stall until three 8-step divisions have run on the one
//  shared divider, each through ST_START and ST_WAIT, and ST_EMIT has loaded
//  the output register; with no qualifying pixel only ST_START and ST_EMIT run.
//  Synchronous active-low reset clears accumulators, control and config.
//  A result word waiting on i_stall does not block the next frame's pixels;
//  only the following frame-end word waits for the output register.
// ----------------------------------------------------------------------------
module masked_color_mean_threshold
    import mcmt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_hue,
    input  logic [PIX_W-1:0]     i_sat,
    input  logic [PIX_W-1:0]     i_bright,
    input  logic                 i_frame_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_low_hue,
    output logic [PIX_W-1:0]     o_low_sat,
    output logic [PIX_W-1:0]     o_low_bright,
    output logic [PIX_W-1:0]     o_high_hue,
    output logic [PIX_W-1:0]     o_high_sat,
    output logic [PIX_W-1:0]     o_high_bright,
    output logic                 o_empty_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    t_state           r_state, n_state;
    logic [1:0]       r_ch;
    logic [PIX_W-1:0] r_mean [0:2];
    logic [PIX_W-1:0] r_sat_floor, r_hue_margin, r_sv_margin, r_sat_ceil, r_val_ceil;
    logic             r_o_valid;
    logic [PIX_W-1:0] r_low_hue, r_low_sat, r_low_bright, r_high_hue, r_high_sat;
    logic [PIX_W-1:0] r_high_bright;
    logic             r_empty;

    t_acc_ctl         w_acc_ctl;
    logic [CNT_W-1:0] w_count;
    logic [SUM_W-1:0] w_hue_sum, w_sat_sum, w_bright_sum, w_dividend;
    logic             w_take, w_start, w_div_done, w_out_free, w_load, w_empty;
    logic [QUO_W-1:0] w_quo;
    logic [PIX_W:0]   w_hh;

    assign w_take     = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_load     = (r_state == ST_EMIT) && w_out_free;
    assign w_start    = (r_state == ST_START) && (w_count != '0);
    assign w_empty    = (w_count == '0);

    assign w_acc_ctl.take = w_take;
    assign w_acc_ctl.clr  = w_load;

    mcmt_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_acc_ctl),
        .i_hue        (i_hue),
        .i_sat        (i_sat),
        .i_bright     (i_bright),
        .i_sat_floor  (r_sat_floor),
        .o_count      (w_count),
        .o_hue_sum    (w_hue_sum),
        .o_sat_sum    (w_sat_sum),
        .o_bright_sum (w_bright_sum)
    );

    always_comb begin
        case (r_ch)
            CH_HUE:    w_dividend = w_hue_sum;
            CH_SAT:    w_dividend = w_sat_sum;
            CH_BRIGHT: w_dividend = w_bright_sum;
            default:   w_dividend = w_hue_sum;
        endcase
    end

    mcmt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_floor  <= RST_SAT_FLOOR;
            r_hue_margin <= RST_HUE_MARGIN;
            r_sv_margin  <= RST_SV_MARGIN;
            r_sat_ceil   <= PIX_MAX;
            r_val_ceil   <= PIX_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAT_FLOOR:     r_sat_floor  <= i_cfg_data;
                REG_HUE_MARGIN:    r_hue_margin <= i_cfg_data;
                REG_SV_MARGIN:     r_sv_margin  <= i_cfg_data;
                REG_SAT_CEILING:   r_sat_ceil   <= i_cfg_data;
                REG_VALUE_CEILING: r_val_ceil   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_take && i_frame_end) n_state = ST_START;
            ST_START: n_state = w_empty ? ST_EMIT : ST_WAIT;
            ST_WAIT:  if (w_div_done) n_state = (r_ch == CH_BRIGHT) ? ST_EMIT : ST_START;
            ST_EMIT:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= CH_HUE;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_ch <= CH_HUE;
            end else if ((r_state == ST_WAIT) && w_div_done) begin
                r_ch <= r_ch + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WAIT) && w_div_done) begin
            r_mean[r_ch] <= w_quo;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    // output word
    assign w_hh = {1'b0, r_mean[0]} + {1'b0, r_hue_margin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_empty       <= w_empty;
            r_high_sat    <= w_empty ? PIX_MAX : r_sat_ceil;
            r_high_bright <= w_empty ? PIX_MAX : r_val_ceil;
            if (w_empty) begin
                r_low_hue    <= '0;
                r_low_sat    <= '0;
                r_low_bright <= '0;
                r_high_hue   <= PIX_MAX;
            end else begin
                r_low_hue    <= (r_mean[0] > r_hue_margin) ? r_mean[0] - r_hue_margin : '0;
                r_low_sat    <= (r_mean[1] > r_sv_margin) ? r_mean[1] - r_sv_margin : '0;
                r_low_bright <= (r_mean[2] > r_sv_margin) ? r_mean[2] - r_sv_margin : '0;
                r_high_hue   <= w_hh[PIX_W] ? PIX_MAX : w_hh[PIX_W-1:0];
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_low_hue     = r_low_hue;
    assign o_low_sat     = r_low_sat;
    assign o_low_bright  = r_low_bright;
    assign o_high_hue    = r_high_hue;
    assign o_high_sat    = r_high_sat;
    assign o_high_bright = r_high_bright;
    assign o_empty_res   = r_empty;

endmodule
